[src/porq_pkg.sv]
// ----------------------------------------------------------------------------
// Picture output reorder queue package
// Shared constants and types for the reorder queue and its slot memory.
// ----------------------------------------------------------------------------
package porq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;  // default number of queue slots
    localparam int MAX_RESULTS     = 16;  // most frames one flush releases
    localparam int HANDLE_W        = 8;
    localparam int ORDER_W         = 32;
    localparam int OCC_W           = 5;   // reported occupancy, modulo 32
    localparam int REORDER_W       = 5;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_BUMP_IF = 2'd1,
        OP_BUMP    = 2'd2,
        OP_FLUSH   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FRAME = 2'd1,
        KIND_FLUSH = 2'd2
    } kind_t;

    // One queue entry; the handle sits in the low bits.
    typedef struct packed {
        logic [ORDER_W-1:0]  oc;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

[src/porq_slot_ram.sv]
// ----------------------------------------------------------------------------
// Reorder queue slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module porq_slot_ram #(
    parameter int DEPTH  = porq_pkg::QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  porq_pkg::slot_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output porq_pkg::slot_t     rdata
);
    import porq_pkg::*;

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/picture_output_reorder_queue.sv]
// ----------------------------------------------------------------------------
// Picture output reorder queue
// Push/no-op items: result goes via RESP to the output; one item at a time.
// Bump: one-entry-per-cycle minimum scan, then one-entry-per-cycle compaction of
//   the entries after the smallest; the result then goes out via RESP.
// Flush: one released frame per cycle while the output is free, then compaction.
// Reset (rst_n low, asynchronous) empties the queue and clears the reorder limit.
// ----------------------------------------------------------------------------
module picture_output_reorder_queue #(
    parameter int QUEUE_DEPTH = porq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] frame_handle, [39:8] order_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_handle, [39:8] out_order_count,
                                        // [44:40] occupancy, [47:45] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] push_dropped
    output logic        m_axis_tlast,   // last
    // Configuration write channel (reorder limit).
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import porq_pkg::*;

    // Fill level holds 0..QUEUE_DEPTH; slot addresses hold 0..QUEUE_DEPTH-1.
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    // Common width for comparing the fill level with 5-bit quantities.
    localparam int CW = (FW > REORDER_W) ? FW : REORDER_W;

    // Sequencer: SCAN walks the queue for the smallest order count, SHIFT
    // moves later entries down one slot per cycle, EMIT streams flushed
    // entries and RESP hands a single result to the output register.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        lim_reg, lim_next;    // fill level when the item arrived
    logic [FW-1:0]        n_reg, n_next;        // frames flushed, or 1 for a bump
    logic [FW-1:0]        idx_reg, idx_next;    // slot whose data the RAM returns
    logic [FW-1:0]        dst_reg, dst_next;    // compaction target slot
    logic [FW-1:0]        best_idx_reg, best_idx_next;
    slot_t                best_slot_reg, best_slot_next;
    kind_t                res_kind_reg, res_kind_next;
    logic                 res_drop_reg, res_drop_next;
    logic [REORDER_W-1:0] reorder_lim_reg;

    // Output register.
    logic                 out_valid_reg;
    kind_t                out_kind_reg;
    slot_t                out_slot_reg;
    logic                 out_last_reg;
    logic                 out_drop_reg;
    logic [OCC_W-1:0]     out_occ_reg;

    logic                 out_free;
    logic                 out_load;
    kind_t                ld_kind;
    slot_t                ld_slot;
    logic                 ld_last;
    logic                 ld_drop;

    // Slot memory ports.
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    slot_t                ram_wdata;
    logic [IW-1:0]        ram_raddr;
    slot_t                ram_rdata;

    slot_t                in_slot;
    op_t                  in_op;
    logic [FW-1:0]        idx_inc;
    logic [FW-1:0]        flush_n;
    logic [FW-1:0]        shift_src;
    logic [FW-1:0]        best_fin_idx;
    logic [FW-1:0]        best_fin_inc;
    slot_t                best_fin_slot;
    logic                 scan_take;
    logic                 bump_skip;

    porq_slot_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_slot.handle = s_axis_tdata[7:0];
    assign in_slot.oc     = s_axis_tdata[39:8];
    assign in_op          = op_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign idx_inc   = idx_reg + FW'(1);
    assign shift_src = dst_reg + n_reg + FW'(1);

    // A flush releases at most MAX_RESULTS of the oldest entries.
    assign flush_n = (CW'(fill_reg) < CW'(MAX_RESULTS)) ? fill_reg : FW'(MAX_RESULTS);

    // A conditional bump does nothing while occupancy is within the limit.
    assign bump_skip = (fill_reg == '0) ||
                       ((in_op == OP_BUMP_IF) && (CW'(fill_reg) <= CW'(reorder_lim_reg)));

    // The first entry always seeds the minimum; later ones replace it only when
    // strictly smaller, so the earliest pushed entry wins a tie.
    assign scan_take     = (idx_reg == '0) ||
                           ($signed(ram_rdata.oc) < $signed(best_slot_reg.oc));
    assign best_fin_idx  = scan_take ? idx_reg : best_idx_reg;
    assign best_fin_slot = scan_take ? ram_rdata : best_slot_reg;
    assign best_fin_inc  = best_fin_idx + FW'(1);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        fill_next      = fill_reg;
        lim_next       = lim_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        best_idx_next  = best_idx_reg;
        best_slot_next = best_slot_reg;
        res_kind_next  = res_kind_reg;
        res_drop_next  = res_drop_reg;

        ram_we    = 1'b0;
        ram_waddr = fill_reg[IW-1:0];
        ram_wdata = in_slot;
        ram_raddr = idx_reg[IW-1:0];

        out_load = 1'b0;
        ld_kind  = res_kind_reg;
        ld_slot  = (res_kind_reg == KIND_NONE) ? '0 : best_slot_reg;
        ld_last  = 1'b1;
        ld_drop  = res_drop_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (s_axis_tvalid)
                begin
                    op_next       = in_op;
                    idx_next      = '0;
                    lim_next      = fill_reg;
                    n_next        = FW'(1);
                    res_kind_next = KIND_NONE;
                    res_drop_next = 1'b0;
                    state_next    = ST_RESP;
                    case (in_op)
                        OP_PUSH:
                        begin
                            if (fill_reg == FW'(QUEUE_DEPTH))
                            begin
                                res_drop_next = 1'b1;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        OP_BUMP_IF, OP_BUMP:
                        begin
                            if (!bump_skip)
                            begin
                                fill_next     = fill_reg - FW'(1);
                                res_kind_next = KIND_FRAME;
                                state_next    = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            if (fill_reg != '0)
                            begin
                                n_next     = flush_n;
                                fill_next  = fill_reg - flush_n;
                                state_next = ST_EMIT;
                            end
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                best_idx_next  = best_fin_idx;
                best_slot_next = best_fin_slot;
                if (idx_inc == lim_reg)
                begin
                    dst_next = best_fin_idx;
                    if (best_fin_inc < lim_reg)
                    begin
                        ram_raddr  = best_fin_inc[IW-1:0];
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[IW-1:0];
                end
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[IW-1:0];
                ram_wdata = ram_rdata;
                if (shift_src < lim_reg)
                begin
                    dst_next  = dst_reg + FW'(1);
                    ram_raddr = shift_src[IW-1:0];
                end
                else if (op_reg == OP_FLUSH)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_EMIT:
            begin
                ld_kind = KIND_FLUSH;
                ld_slot = ram_rdata;
                ld_last = (idx_inc == n_reg);
                ld_drop = 1'b0;
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (idx_inc == n_reg)
                    begin
                        // Entries beyond the released ones move down to slot 0.
                        if (n_reg < lim_reg)
                        begin
                            dst_next   = '0;
                            ram_raddr  = n_reg[IW-1:0];
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_raddr = idx_inc[IW-1:0];
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= OP_PUSH;
            fill_reg        <= '0;
            lim_reg         <= '0;
            n_reg           <= '0;
            idx_reg         <= '0;
            dst_reg         <= '0;
            best_idx_reg    <= '0;
            res_kind_reg    <= KIND_NONE;
            res_drop_reg    <= 1'b0;
            reorder_lim_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            fill_reg     <= fill_next;
            lim_reg      <= lim_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            dst_reg      <= dst_next;
            best_idx_reg <= best_idx_next;
            res_kind_reg <= res_kind_next;
            res_drop_reg <= res_drop_next;
            if (cfg_valid)
            begin
                reorder_lim_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        best_slot_reg <= best_slot_next;
        if (out_load)
        begin
            out_kind_reg <= ld_kind;
            out_slot_reg <= ld_slot;
            out_last_reg <= ld_last;
            out_drop_reg <= ld_drop;
            // The fill level already holds its value after this item.
            out_occ_reg  <= OCC_W'(fill_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_slot_reg.oc, out_slot_reg.handle};
    assign m_axis_tuser  = {out_drop_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[verif/porq_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reorder queue checker
// Watches the input, result and register channels of the picture output
// reorder queue. It keeps its own copy of the queued pictures and predicts the
// results of every accepted item, then compares each result transfer with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module porq_checker #(
    parameter int QUEUE_DEPTH = porq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] frame_handle, [39:8] order_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [7:0] handle, [39:8] order count, [44:40] occupancy
    input  logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] push_dropped
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output int          errors,
    output int          outstanding,
    output int          results_seen
);
    import porq_pkg::*;

    typedef struct {
        kind_t                kind;
        logic [HANDLE_W-1:0]  handle;
        logic [ORDER_W-1:0]   oc;
        logic                 last;
        logic                 dropped;
        logic [OCC_W-1:0]     occ;
    } result_t;

    slot_t                  pics[$];        // queued pictures, oldest first
    result_t                frames_due[$];  // predicted results not yet seen
    logic [REORDER_W-1:0]   reorder_limit;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("%0t ns: mismatch on %s, expected %h, got %h (result %0d)",
                 $time, what, want, got, results_seen);
    endtask

    // Applies one operation to the picture queue and queues up its results.
    task automatic predict_results(input op_t op, input logic [HANDLE_W-1:0] h,
                                   input logic [ORDER_W-1:0] oc);
        result_t r;
        slot_t   s;
        int      best;
        int      n;
        int      rest;
        r.kind    = KIND_NONE;
        r.handle  = '0;
        r.oc      = '0;
        r.last    = 1'b1;
        r.dropped = 1'b0;
        r.occ     = '0;
        case (op)
            OP_PUSH:
            begin
                if (pics.size() >= QUEUE_DEPTH) begin
                    r.dropped = 1'b1;
                end
                else begin
                    s.handle = h;
                    s.oc     = oc;
                    pics.push_back(s);
                end
                r.occ = OCC_W'(pics.size());
                frames_due.push_back(r);
            end
            OP_BUMP_IF, OP_BUMP:
            begin
                if (pics.size() != 0 && (op == OP_BUMP || pics.size() > reorder_limit)) begin
                    // Strict compare keeps the earliest pushed entry on a tie.
                    best = 0;
                    for (int i = 1; i < pics.size(); i++) begin
                        if ($signed(pics[i].oc) < $signed(pics[best].oc)) begin
                            best = i;
                        end
                    end
                    r.kind   = KIND_FRAME;
                    r.handle = pics[best].handle;
                    r.oc     = pics[best].oc;
                    pics.delete(best);
                end
                r.occ = OCC_W'(pics.size());
                frames_due.push_back(r);
            end
            default:
            begin
                n = (pics.size() < MAX_RESULTS) ? pics.size() : MAX_RESULTS;
                rest = pics.size() - n;
                if (n == 0) begin
                    frames_due.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    s        = pics.pop_front();
                    r.kind   = KIND_FLUSH;
                    r.handle = s.handle;
                    r.oc     = s.oc;
                    r.last   = (i == n - 1);
                    r.occ    = OCC_W'(rest);
                    frames_due.push_back(r);
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t r;
        if (!rst_n) begin
            pics.delete();
            frames_due.delete();
            reorder_limit = '0;
            errors        = 0;
            results_seen  = 0;
            outstanding  <= 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_results(op_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[39:8]);
            end
            if (cfg_valid && cfg_ready) begin
                reorder_limit = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (frames_due.size() == 0) begin
                    report_mismatch("result with nothing due", '0, m_axis_tdata[31:0]);
                end
                else begin
                    r = frames_due.pop_front();
                    if (m_axis_tuser[1:0] !== r.kind)
                        report_mismatch("kind", r.kind, m_axis_tuser[1:0]);
                    if (m_axis_tdata[7:0] !== r.handle)
                        report_mismatch("out_handle", r.handle, m_axis_tdata[7:0]);
                    if (m_axis_tdata[39:8] !== r.oc)
                        report_mismatch("out_order_count", r.oc, m_axis_tdata[39:8]);
                    if (m_axis_tlast !== r.last)
                        report_mismatch("last", r.last, m_axis_tlast);
                    if (m_axis_tuser[2] !== r.dropped)
                        report_mismatch("push_dropped", r.dropped, m_axis_tuser[2]);
                    if (m_axis_tdata[44:40] !== r.occ)
                        report_mismatch("occupancy", r.occ, m_axis_tdata[44:40]);
                end
            end
            outstanding <= frames_due.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Picture output reorder queue testbench
// Drives pushes, bumps and flushes into the reorder queue under several
// reorder limit settings and idle patterns; a separate checker predicts and
// compares every result while this top makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import porq_pkg::*;

    localparam int DEPTH          = QUEUE_DEPTH_DEF;
    // A flush deeper than the result limit may still be compacting the queue
    // after its last result has left, so register writes and the end of the
    // run wait this long once drained.
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_ITEMS   = 385;
    localparam int NUM_PHASES     = 5;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // [7:0] frame_handle, [39:8] order_count
    logic [1:0]  s_axis_tuser  = OP_PUSH;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [7:0] handle, [39:8] order count, [44:40] occupancy
    logic [2:0]  m_axis_tuser;          // [1:0] kind, [2] push_dropped
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data      = '0;

    int errors;
    int outstanding;
    int results_seen;

    int items_sent  = 0;
    int cfg_writes  = 0;
    int gap_pct     = 0;    // read only by the stimulus process
    int stall_pct   = 0;    // read by the receiver process
    bit hold_toggle = 1'b0; // each flip asks the receiver for one long hold-off
    bit hold_seen   = 1'b0;
    int hold_left   = 0;
    int quiet_run   = 0;
    logic [ORDER_W-1:0] poc_base = '0;

    always #1 clk = ~clk;

    picture_output_reorder_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    porq_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // Result side. A requested hold-off keeps tready low for a long stretch,
    // counted here; otherwise tready drops at random at the current stall rate.
    always @(posedge clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // The watchdog only counts cycles without any transfer, so slow but
    // correct stretches never trip it while a hung block does.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_run <= 0;
        end
        else if (quiet_run >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer in %0d cycles, %0d results still due",
                     quiet_run, outstanding);
            $display("FAILURE");
            $finish;
        end
        else begin
            quiet_run <= quiet_run + 1;
        end
    end

    // Offers one item and returns at the edge of its transfer with tvalid
    // still high. The caller must follow with another send_item or with
    // wait_quiet in the same time step, so the item is never offered twice.
    task automatic send_item(input op_t op, input logic [HANDLE_W-1:0] handle,
                             input logic [ORDER_W-1:0] poc);
        int gap;
        gap = 0;
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {poc, handle};
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has come,
    // then lets the block settle for the given number of cycles.
    task automatic wait_quiet(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reorder(input logic [REORDER_W-1:0] limit);
        wait_quiet(DRAIN_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // One group of pictures as a decoder would send it: each frame pushed with
    // an order count near the running base, mostly followed by a conditional
    // bump, and now and then a flush, a forced bump or a jump of the base.
    task automatic send_gop();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            send_item(OP_PUSH, HANDLE_W'($urandom_range(255)),
                      poc_base + ORDER_W'($urandom_range(0, 2 * len)));
            if ($urandom_range(3) != 0) begin
                send_item(OP_BUMP_IF, HANDLE_W'($urandom_range(255)), $urandom());
            end
        end
        poc_base = poc_base + ORDER_W'(2 * len + 1);
        case ($urandom_range(7))
            0:       send_item(OP_FLUSH, HANDLE_W'($urandom_range(255)), $urandom());
            1:       send_item(OP_BUMP, HANDLE_W'($urandom_range(255)), $urandom());
            2:       poc_base = $urandom();
            default: ;
        endcase
    endtask

    initial begin : stimulus
        int limits [NUM_PHASES];
        int gaps   [NUM_PHASES];
        int stalls [NUM_PHASES];
        int target;
        bit held;
        bit paused;
        limits = '{3, 16, 1, 15, 0};
        gaps   = '{0, 73, 0, 26, 0};
        stalls = '{0, 0, 73, 26, 0};
        held   = 1'b0;
        paused = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reorder limit at its reset value of zero.
        send_item(OP_FLUSH, 8'h00, '0);              // flush of an empty queue
        send_item(OP_BUMP_IF, 8'hff, 32'hffff_ffff); // bumps of an empty queue
        send_item(OP_BUMP, 8'h00, '0);
        send_item(OP_PUSH, 8'hff, 32'h7fff_ffff);    // largest order count
        send_item(OP_PUSH, 8'h00, 32'h8000_0000);    // smallest order count
        send_item(OP_PUSH, 8'h5a, 32'd5);
        send_item(OP_PUSH, 8'ha5, 32'd5);            // tie with the entry before
        send_item(OP_BUMP_IF, 8'h00, '0);            // occupancy above zero: pops
        send_item(OP_BUMP, 8'h00, '0);               // tie goes to the earlier push
        for (int i = 0; i < DEPTH - 2; i++) begin
            send_item(OP_PUSH, HANDLE_W'($urandom_range(255)), $urandom());
        end
        send_item(OP_PUSH, 8'h77, 32'd1);            // queue full: dropped
        send_item(OP_BUMP_IF, 8'h00, '0);
        send_item(OP_FLUSH, 8'h00, '0);              // long run of released frames

        // Random part: groups of pictures with some noise items mixed in.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reorder(REORDER_W'(limits[p]));
            gap_pct    = gaps[p];
            stall_pct <= stalls[p];
            target     = items_sent + RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < target) begin
                // With no idling on the input, a long receiver hold-off stalls the
                // block on its held result and makes it push back on the sender.
                if (p == 0 && !held && items_sent + 50 > target) begin
                    hold_toggle <= ~hold_toggle;
                    held = 1'b1;
                end
                // Once the sender stops until every result has come.
                if (p == 3 && !paused && items_sent + 40 > target) begin
                    wait_quiet(0);
                    paused = 1'b1;
                end
                if ($urandom_range(4) == 0) begin
                    send_item(op_t'($urandom_range(3)), HANDLE_W'($urandom_range(255)),
                              $urandom());
                end
                else begin
                    send_gop();
                end
            end
        end

        wait_quiet(DRAIN_CYCLES);
        $display("Run covered %0d input transfers, %0d result transfers and %0d",
                 items_sent, results_seen, cfg_writes);
        $display("reorder limit writes across idle, stall and long hold-off phases.");
        if (errors == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
